>>> src/rsub_pkg.sv
`default_nettype none
package rsub_pkg;

   // Default coordinate width of the origin fields
   localparam int COORD_BITS_DEFAULT = 16;

   // Depth of the queue between classification and piece emission
   localparam int QUEUE_DEPTH = 4;

   // Bit positions of the strips in the piece mask, in emission order
   localparam int MASK_LEFT   = 0;
   localparam int MASK_RIGHT  = 1;
   localparam int MASK_TOP    = 2;
   localparam int MASK_BOTTOM = 3;
   localparam int MASK_BITS   = 4;

   // Classified item: B misses A, and which strips remain
   typedef struct packed {
      logic                 miss;
      logic [MASK_BITS-1:0] mask;
   } rsub_plan_type;

   // Piece chosen by the emitter in one cycle
   typedef enum logic [2:0] {
      PIECE_LEFT,
      PIECE_RIGHT,
      PIECE_TOP,
      PIECE_BOTTOM,
      PIECE_WHOLE,
      PIECE_NONE
   } rsub_piece_type;

   // Width of the geometry carried through the queue
   function automatic int rsub_entry_bits(input int coord_bits);
      return 12 * coord_bits - 4;
   endfunction

endpackage
`default_nettype wire

>>> src/rsub_front.sv
`default_nettype none
module rsub_front #(
   parameter int COORD_BITS = rsub_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             in_valid,
   output logic                                             in_ready,
   input  logic signed [COORD_BITS-1:0]                     a_x,
   input  logic signed [COORD_BITS-1:0]                     a_y,
   input  logic        [COORD_BITS-2:0]                     a_w,
   input  logic        [COORD_BITS-2:0]                     a_h,
   input  logic signed [COORD_BITS-1:0]                     b_x,
   input  logic signed [COORD_BITS-1:0]                     b_y,
   input  logic        [COORD_BITS-2:0]                     b_w,
   input  logic        [COORD_BITS-2:0]                     b_h,
   output logic                                             out_valid,
   input  logic                                             out_ready,
   output rsub_pkg::rsub_plan_type                          out_plan,
   output logic [rsub_pkg::rsub_entry_bits(COORD_BITS)-1:0] out_data
);

   // Wide enough that no overhang wraps
   localparam int W = COORD_BITS + 2;

   typedef struct packed {
      logic [COORD_BITS-1:0] ax;
      logic [COORD_BITS-1:0] ay;
      logic [COORD_BITS-2:0] aw;
      logic [COORD_BITS-2:0] ah;
      logic [COORD_BITS-2:0] dl;
      logic [COORD_BITS-2:0] dr;
      logic [COORD_BITS-2:0] dt;
      logic [COORD_BITS-2:0] db;
      logic [COORD_BITS:0]   rx;
      logic [COORD_BITS:0]   mx;
      logic [COORD_BITS:0]   by;
      logic [COORD_BITS-2:0] mw;
   } entry_type;

   logic signed [W-1:0] ax_e, ay_e, aw_e, ah_e, bx_e, by_e, bw_e, bh_e;
   logic signed [W-1:0] dl_in, dr_in, dt_in, db_in, bxw_in, byh_in;

   logic                  s_valid_ff;
   logic [COORD_BITS-1:0] s_ax_ff, s_ay_ff;
   logic [COORD_BITS-2:0] s_aw_ff, s_ah_ff;
   logic signed [W-1:0]   s_dl_ff, s_dr_ff, s_dt_ff, s_db_ff, s_bxw_ff, s_byh_ff;

   logic signed [W-1:0] sax, saw, sah, dl0, dr0, mx, mw;
   logic                miss;
   entry_type           entry;

   // Widen the operands
   always_comb begin
      ax_e = {{2{a_x[COORD_BITS-1]}}, a_x};
      ay_e = {{2{a_y[COORD_BITS-1]}}, a_y};
      bx_e = {{2{b_x[COORD_BITS-1]}}, b_x};
      by_e = {{2{b_y[COORD_BITS-1]}}, b_y};
      aw_e = {3'b000, a_w};
      ah_e = {3'b000, a_h};
      bw_e = {3'b000, b_w};
      bh_e = {3'b000, b_h};
      bxw_in = bx_e + bw_e;
      byh_in = by_e + bh_e;
      dl_in  = bx_e - ax_e;
      dt_in  = by_e - ay_e;
      dr_in  = (ax_e + aw_e) - bxw_in;
      db_in  = (ay_e + ah_e) - byh_in;
   end

   // Take a transaction whenever the stage is empty or drains into the queue
   assign in_ready  = !s_valid_ff || out_ready;
   assign out_valid = s_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (in_ready) begin
         s_valid_ff <= in_valid;
      end
   end

   // Hold the overhangs for classification
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         s_ax_ff  <= a_x;
         s_ay_ff  <= a_y;
         s_aw_ff  <= a_w;
         s_ah_ff  <= a_h;
         s_dl_ff  <= dl_in;
         s_dr_ff  <= dr_in;
         s_dt_ff  <= dt_in;
         s_db_ff  <= db_in;
         s_bxw_ff <= bxw_in;
         s_byh_ff <= byh_in;
      end
   end

   // Classify: miss test, remaining strips, middle column span
   always_comb begin
      sax  = {{2{s_ax_ff[COORD_BITS-1]}}, s_ax_ff};
      saw  = {3'b000, s_aw_ff};
      sah  = {3'b000, s_ah_ff};
      miss = (s_dl_ff >= saw) || (s_dr_ff >= saw) || (s_dt_ff >= sah) || (s_db_ff >= sah);
      dl0  = (s_dl_ff > 0) ? s_dl_ff : '0;
      dr0  = (s_dr_ff > 0) ? s_dr_ff : '0;
      mx   = sax + dl0;
      mw   = saw - dl0 - dr0;

      out_plan.miss = miss;
      out_plan.mask = '0;
      if (!miss) begin
         out_plan.mask[rsub_pkg::MASK_LEFT]   = s_dl_ff > 0;
         out_plan.mask[rsub_pkg::MASK_RIGHT]  = s_dr_ff > 0;
         out_plan.mask[rsub_pkg::MASK_TOP]    = s_dt_ff > 0;
         out_plan.mask[rsub_pkg::MASK_BOTTOM] = s_db_ff > 0;
      end

      entry.ax = s_ax_ff;
      entry.ay = s_ay_ff;
      entry.aw = s_aw_ff;
      entry.ah = s_ah_ff;
      entry.dl = s_dl_ff[COORD_BITS-2:0];
      entry.dr = s_dr_ff[COORD_BITS-2:0];
      entry.dt = s_dt_ff[COORD_BITS-2:0];
      entry.db = s_db_ff[COORD_BITS-2:0];
      entry.rx = s_bxw_ff[COORD_BITS:0];
      entry.by = s_byh_ff[COORD_BITS:0];
      entry.mx = mx[COORD_BITS:0];
      entry.mw = mw[COORD_BITS-2:0];
      // The top edge, shared by the left, right, top and whole pieces, is carried in ay
      out_data = entry;
   end

endmodule
`default_nettype wire

>>> src/rsub_queue.sv
`default_nettype none
module rsub_queue #(
   parameter int DATA_BITS = rsub_pkg::rsub_entry_bits(rsub_pkg::COORD_BITS_DEFAULT)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  rsub_pkg::rsub_plan_type push_plan,
   input  logic [DATA_BITS-1:0]    push_data,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output rsub_pkg::rsub_plan_type pop_plan,
   output logic [DATA_BITS-1:0]    pop_data
);

   localparam int DEPTH    = rsub_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   rsub_pkg::rsub_plan_type plan_mem_ff [DEPTH];
   logic [DATA_BITS-1:0]    data_mem_ff [DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0]     count_ff;
   logic                    push, pop;

   assign push_ready = count_ff != CNT_BITS'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_plan   = plan_mem_ff[rd_ptr_ff];
   assign pop_data   = data_mem_ff[rd_ptr_ff];

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         plan_mem_ff[wr_ptr_ff] <= push_plan;
         data_mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

>>> src/rsub_back.sv
`default_nettype none
module rsub_back #(
   parameter int COORD_BITS = rsub_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             in_valid,
   output logic                                             in_ready,
   input  rsub_pkg::rsub_plan_type                          in_plan,
   input  logic [rsub_pkg::rsub_entry_bits(COORD_BITS)-1:0] in_data,
   output logic                                             out_valid,
   input  logic                                             out_ready,
   output logic [COORD_BITS:0]                              piece_x,
   output logic [COORD_BITS:0]                              piece_y,
   output logic [COORD_BITS-2:0]                            piece_w,
   output logic [COORD_BITS-2:0]                            piece_h,
   output logic                                             piece_present,
   output logic                                             last_piece
);

   localparam int MB = rsub_pkg::MASK_BITS;

   typedef struct packed {
      logic [COORD_BITS-1:0] ax;
      logic [COORD_BITS-1:0] ay;
      logic [COORD_BITS-2:0] aw;
      logic [COORD_BITS-2:0] ah;
      logic [COORD_BITS-2:0] dl;
      logic [COORD_BITS-2:0] dr;
      logic [COORD_BITS-2:0] dt;
      logic [COORD_BITS-2:0] db;
      logic [COORD_BITS:0]   rx;
      logic [COORD_BITS:0]   mx;
      logic [COORD_BITS:0]   by;
      logic [COORD_BITS-2:0] mw;
   } entry_type;

   entry_type               entry;
   logic                    started_ff;
   logic [MB-1:0]           rem_ff;
   logic                    out_valid_ff;
   logic [COORD_BITS:0]     x_ff, y_ff;
   logic [COORD_BITS-2:0]   w_ff, h_ff;
   logic                    present_ff, last_ff;

   logic [MB-1:0]           mask, lowbit, rest;
   logic                    adv, fire, last;
   rsub_pkg::rsub_piece_type kind;
   logic [COORD_BITS:0]     x_in, y_in, ax_w, ay_w;
   logic [COORD_BITS-2:0]   w_in, h_in;
   logic                    present_in;

   assign entry = in_data;

   // Pick the next strip of the current entry, lowest mask bit first
   always_comb begin
      adv    = !out_valid_ff || out_ready;
      mask   = started_ff ? rem_ff : in_plan.mask;
      lowbit = mask & (~mask + 1'b1);
      rest   = mask & ~lowbit;
      last   = rest == '0;
      fire   = in_valid && adv;
      in_ready = fire && last;

      if (lowbit[rsub_pkg::MASK_LEFT]) begin
         kind = rsub_pkg::PIECE_LEFT;
      end else if (lowbit[rsub_pkg::MASK_RIGHT]) begin
         kind = rsub_pkg::PIECE_RIGHT;
      end else if (lowbit[rsub_pkg::MASK_TOP]) begin
         kind = rsub_pkg::PIECE_TOP;
      end else if (lowbit[rsub_pkg::MASK_BOTTOM]) begin
         kind = rsub_pkg::PIECE_BOTTOM;
      end else if (in_plan.miss) begin
         kind = rsub_pkg::PIECE_WHOLE;
      end else begin
         kind = rsub_pkg::PIECE_NONE;
      end
   end

   // Form the piece geometry
   always_comb begin
      ax_w       = {entry.ax[COORD_BITS-1], entry.ax};
      ay_w       = {entry.ay[COORD_BITS-1], entry.ay};
      x_in       = '0;
      y_in       = '0;
      w_in       = '0;
      h_in       = '0;
      present_in = 1'b1;
      case (kind)
         rsub_pkg::PIECE_LEFT: begin
            x_in = ax_w;
            y_in = ay_w;
            w_in = entry.dl;
            h_in = entry.ah;
         end
         rsub_pkg::PIECE_RIGHT: begin
            x_in = entry.rx;
            y_in = ay_w;
            w_in = entry.dr;
            h_in = entry.ah;
         end
         rsub_pkg::PIECE_TOP: begin
            x_in = entry.mx;
            y_in = ay_w;
            w_in = entry.mw;
            h_in = entry.dt;
         end
         rsub_pkg::PIECE_BOTTOM: begin
            x_in = entry.mx;
            y_in = entry.by;
            w_in = entry.mw;
            h_in = entry.db;
         end
         rsub_pkg::PIECE_WHOLE: begin
            x_in = ax_w;
            y_in = ay_w;
            w_in = entry.aw;
            h_in = entry.ah;
         end
         default: begin
            present_in = 1'b0;
         end
      endcase
   end

   // Walk the strips and hold the output transaction until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            out_valid_ff <= in_valid;
         end
         if (fire) begin
            started_ff <= !last;
            rem_ff     <= rest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         x_ff       <= x_in;
         y_ff       <= y_in;
         w_ff       <= w_in;
         h_ff       <= h_in;
         present_ff <= present_in;
         last_ff    <= last;
      end
   end

   assign out_valid     = out_valid_ff;
   assign piece_x       = x_ff;
   assign piece_y       = y_ff;
   assign piece_w       = w_ff;
   assign piece_h       = h_ff;
   assign piece_present = present_ff;
   assign last_piece    = last_ff;

endmodule
`default_nettype wire

>>> src/rectangle_subtract_pieces.sv
`default_nettype none
// Cuts rectangle B out of rectangle A and returns what is left of A as one to
// four pieces, in the order left strip, right strip, top strip, bottom strip
// (top and bottom span only the columns between the side strips). If B misses
// A, A comes back unchanged; if B covers A, one transaction with piece_present
// low is returned. The last piece of each request carries rsp_tlast. The piece
// emitter sends one piece per cycle unless the output stalls, and takes the
// next request with the last piece. A request passes the classification
// register, the queue and the emitter's output register. A four-entry queue
// lets the request side keep classifying while the response side is stalled.
module rectangle_subtract_pieces #(
   parameter int COORD_BITS = rsub_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h from bit 0 up, zero padded
   input  logic [((8*COORD_BITS-4)+7)/8*8-1:0]       req_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // piece_x, piece_y, piece_w, piece_h from bit 0 up, zero padded
   output logic [((4*COORD_BITS)+7)/8*8-1:0]         rsp_tdata,
   // piece_present
   output logic                                      rsp_tuser,
   // last_piece
   output logic                                      rsp_tlast
);

   localparam int C      = COORD_BITS;
   localparam int EBITS  = rsub_pkg::rsub_entry_bits(COORD_BITS);
   localparam int RBITS  = ((4*COORD_BITS)+7)/8*8;
   localparam int O_AY   = C;
   localparam int O_AW   = 2*C;
   localparam int O_AH   = 3*C - 1;
   localparam int O_BX   = 4*C - 2;
   localparam int O_BY   = 5*C - 2;
   localparam int O_BW   = 6*C - 2;
   localparam int O_BH   = 7*C - 3;

   logic                    f_valid, f_ready, b_valid, b_ready;
   rsub_pkg::rsub_plan_type f_plan, b_plan;
   logic [EBITS-1:0]        f_data, b_data;
   logic [C:0]              piece_x, piece_y;
   logic [C-2:0]            piece_w, piece_h;

   rsub_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .a_x       (req_tdata[C-1:0]),
      .a_y       (req_tdata[O_AY+C-1:O_AY]),
      .a_w       (req_tdata[O_AW+C-2:O_AW]),
      .a_h       (req_tdata[O_AH+C-2:O_AH]),
      .b_x       (req_tdata[O_BX+C-1:O_BX]),
      .b_y       (req_tdata[O_BY+C-1:O_BY]),
      .b_w       (req_tdata[O_BW+C-2:O_BW]),
      .b_h       (req_tdata[O_BH+C-2:O_BH]),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_plan  (f_plan),
      .out_data  (f_data)
   );

   rsub_queue #(.DATA_BITS(EBITS)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_plan  (f_plan),
      .push_data  (f_data),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_plan   (b_plan),
      .pop_data   (b_data)
   );

   rsub_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (b_valid),
      .in_ready      (b_ready),
      .in_plan       (b_plan),
      .in_data       (b_data),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .piece_x       (piece_x),
      .piece_y       (piece_y),
      .piece_w       (piece_w),
      .piece_h       (piece_h),
      .piece_present (rsp_tuser),
      .last_piece    (rsp_tlast)
   );

   // Pack the response fields, padding with zeros
   assign rsp_tdata = RBITS'({piece_h, piece_w, piece_y, piece_x});

endmodule
`default_nettype wire
